### src/gsds_pkg.sv
// ----------------------------------------------------------------------------
// gsds_pkg
// Shared types and fixed-point constants for the stride distance and speed block
// ----------------------------------------------------------------------------
package gsds_pkg;

    // field widths
    localparam int GYRO_W   = 16;
    localparam int ABS_W    = 16;
    localparam int PEAK_W   = 16;
    localparam int SUM_W    = 32;
    localparam int STEP_W   = 16;
    localparam int SPEED_W  = 24;
    localparam int CNT_W    = 8;

    // configuration register widths
    localparam int LEG_W    = 17;
    localparam int FLOOR_W  = 15;
    localparam int FRAC_W   = 16;
    localparam int MINSP_W  = 16;
    localparam int WIN_W    = 6;
    localparam int IVAL_W   = 8;

    // apb port
    localparam int PDATA_W  = 32;
    localparam int PADDR_W  = 5;

    // digit-serial multiplier: 32 x 32 bits, 4-bit digits
    localparam int MUL_W      = 32;
    localparam int DIGIT_W    = 4;
    localparam int MUL_DIGITS = MUL_W / DIGIT_W;

    // half angle per count, Q40
    localparam logic [MUL_W-1:0] HALF_ANGLE_Q40 = 32'd4197834;
    // reciprocals, exact over the value ranges below
    // x3 < 2^24: floor(x3 / 6) = (x3 * RECIP6) >> 27
    // x5 < 2^18: floor(x5 / 120) = (x5 * RECIP120) >> 25
    localparam logic [MUL_W-1:0] RECIP6   = 32'd22369622;
    localparam logic [MUL_W-1:0] RECIP120 = 32'd279621;

    // product slices of the sine series
    localparam int SH_X    = 8;
    localparam int SH_SQ   = 32;
    localparam int SH_Q3   = 27;
    localparam int SH_Q5   = 25;
    localparam int SH_STEP = 31;
    localparam int X_W     = 30;
    localparam int X2_W    = 27;
    localparam int X3_W    = 24;
    localparam int X5_W    = 18;
    localparam int Q3_W    = 21;
    localparam int Q5_W    = 11;

    // register reset values
    localparam logic [LEG_W-1:0]   LEG_RST   = 17'd61276;
    localparam logic [FLOOR_W-1:0] FLOOR_RST = 15'd4000;
    localparam logic [FRAC_W-1:0]  FRAC_RST  = 16'd3277;
    localparam logic [MINSP_W-1:0] MINSP_RST = 16'd3277;
    localparam logic [WIN_W-1:0]   WIN_RST   = 6'd4;
    localparam logic [IVAL_W-1:0]  IVAL_RST  = 8'd10;

    typedef struct packed {
        logic [LEG_W-1:0]   leg_length;
        logic [FLOOR_W-1:0] peak_floor;
        logic [FRAC_W-1:0]  trigger_fraction;
        logic [MINSP_W-1:0] min_speed;
        logic [WIN_W-1:0]   window_entries;
        logic [IVAL_W-1:0]  interval_samples;
    } t_cfg;

    // commands to the speed history
    typedef struct packed {
        logic clear;
        logic push;
        logic start;
    } t_hist_ctl;

endpackage

### src/gsds_apb_regs.sv
// ----------------------------------------------------------------------------
// gsds_apb_regs
// APB configuration registers, one 32-bit word per register
// ----------------------------------------------------------------------------
module gsds_apb_regs
    import gsds_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    typedef enum logic [2:0] {
        REG_LEG_LENGTH       = 3'd0,
        REG_PEAK_FLOOR       = 3'd1,
        REG_TRIGGER_FRACTION = 3'd2,
        REG_MIN_SPEED        = 3'd3,
        REG_WINDOW_ENTRIES   = 3'd4,
        REG_INTERVAL_SAMPLES = 3'd5
    } t_reg_idx;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[PADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite && pready;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.leg_length       <= LEG_RST;
            r_cfg.peak_floor       <= FLOOR_RST;
            r_cfg.trigger_fraction <= FRAC_RST;
            r_cfg.min_speed        <= MINSP_RST;
            r_cfg.window_entries   <= WIN_RST;
            r_cfg.interval_samples <= IVAL_RST;
        end else if (w_wr) begin
            case (w_idx)
                REG_LEG_LENGTH:       r_cfg.leg_length       <= pwdata[LEG_W-1:0];
                REG_PEAK_FLOOR:       r_cfg.peak_floor       <= pwdata[FLOOR_W-1:0];
                REG_TRIGGER_FRACTION: r_cfg.trigger_fraction <= pwdata[FRAC_W-1:0];
                REG_MIN_SPEED:        r_cfg.min_speed        <= pwdata[MINSP_W-1:0];
                REG_WINDOW_ENTRIES:   r_cfg.window_entries   <= pwdata[WIN_W-1:0];
                REG_INTERVAL_SAMPLES: r_cfg.interval_samples <= pwdata[IVAL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_LEG_LENGTH:       prdata = PDATA_W'(r_cfg.leg_length);
            REG_PEAK_FLOOR:       prdata = PDATA_W'(r_cfg.peak_floor);
            REG_TRIGGER_FRACTION: prdata = PDATA_W'(r_cfg.trigger_fraction);
            REG_MIN_SPEED:        prdata = PDATA_W'(r_cfg.min_speed);
            REG_WINDOW_ENTRIES:   prdata = PDATA_W'(r_cfg.window_entries);
            REG_INTERVAL_SAMPLES: prdata = PDATA_W'(r_cfg.interval_samples);
            default:              prdata = '0;
        endcase
    end

endmodule

### src/gsds_ser_mul.sv
// ----------------------------------------------------------------------------
// gsds_ser_mul
// Digit-serial unsigned multiplier, one 4-bit digit of the multiplier per cycle
// ----------------------------------------------------------------------------
module gsds_ser_mul
    import gsds_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [MUL_W-1:0]     i_a,
    input  logic [MUL_W-1:0]     i_b,
    output logic                 o_done,
    output logic [2*MUL_W-1:0]   o_prod
);

    localparam int                CW       = $clog2(MUL_DIGITS);
    localparam int                PW       = MUL_W + DIGIT_W;
    localparam logic [CW-1:0]     CNT_LAST = CW'(MUL_DIGITS - 1);

    logic [MUL_W-1:0]   r_a;
    logic [MUL_W-1:0]   r_b;
    logic [2*MUL_W-1:0] r_p;
    logic [CW-1:0]      r_cnt;
    logic               r_busy;
    logic               r_done;
    logic [PW-1:0]      w_hi;

    // upper half plus multiplicand times the low digit
    assign w_hi = {{DIGIT_W{1'b0}}, r_p[2*MUL_W-1:MUL_W]}
                + (PW'(r_a) * PW'(r_b[DIGIT_W-1:0]));

    assign o_done = r_done;
    assign o_prod = r_p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
            r_p <= '0;
        end else if (r_busy) begin
            r_p <= {w_hi, r_p[MUL_W-1:DIGIT_W]};
            r_b <= r_b >> DIGIT_W;
        end
    end

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("multiplier started while busy");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !r_busy)
        else $error("multiplier done while still busy");

    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_cnt == CNT_LAST) |=> o_done)
        else $error("multiplier missed done after last digit");

endmodule

### src/gsds_spd_hist.sv
// ----------------------------------------------------------------------------
// gsds_spd_hist
// Speed history ring buffer and serial window maximum search
// ----------------------------------------------------------------------------
module gsds_spd_hist
    import gsds_pkg::*;
#(
    parameter int DEPTH = 40
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_hist_ctl          i_ctl,
    input  logic [SPEED_W-1:0] i_push_data,
    input  logic [WIN_W-1:0]   i_window,
    input  logic [MINSP_W-1:0] i_min_speed,
    output logic               o_done,
    output logic [SPEED_W-1:0] o_shown
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_FINAL
    } t_state;

    t_state             r_state;
    logic [SPEED_W-1:0] r_mem [DEPTH];
    logic [SPEED_W-1:0] r_rd_data;
    logic               r_rd_vld;
    logic               r_rd_ok;
    logic [AW-1:0]      r_wp;
    logic [AW-1:0]      r_rp;
    logic [CW-1:0]      r_fill;
    logic [CW-1:0]      r_idx;
    logic [CW-1:0]      r_n;
    logic [SPEED_W-1:0] r_best;
    logic [SPEED_W-1:0] r_shown;
    logic               r_done;

    logic [CW-1:0]      w_n;
    logic [AW-1:0]      w_newest;
    logic [AW-1:0]      w_prev;
    logic [SPEED_W-1:0] w_best;

    // window clamped to one entry at least and to the table size at most
    always_comb begin
        if (i_window == '0) begin
            w_n = CW'(1);
        end else if (int'(i_window) > DEPTH) begin
            w_n = CW'(DEPTH);
        end else begin
            w_n = CW'(i_window);
        end
    end

    assign w_newest = (r_wp == '0) ? AW'(DEPTH - 1) : r_wp - 1'b1;
    assign w_prev   = (r_rp == '0) ? AW'(DEPTH - 1) : r_rp - 1'b1;
    // entries past the fill count read as zero
    assign w_best   = (r_rd_vld && r_rd_ok && r_rd_data > r_best) ? r_rd_data : r_best;

    assign o_done  = r_done;
    assign o_shown = r_shown;

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_mem[r_wp] <= i_push_data;
        end
        r_rd_data <= r_mem[r_rp];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_wp     <= '0;
            r_rp     <= '0;
            r_fill   <= '0;
            r_idx    <= '0;
            r_n      <= '0;
            r_rd_vld <= 1'b0;
            r_rd_ok  <= 1'b0;
            r_best   <= '0;
            r_shown  <= '0;
            r_done   <= 1'b0;
        end else begin
            r_done   <= 1'b0;
            r_rd_vld <= 1'b0;

            if (i_ctl.clear) begin
                r_wp   <= '0;
                r_fill <= '0;
            end else if (i_ctl.push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
                if (r_fill != CW'(DEPTH)) begin
                    r_fill <= r_fill + 1'b1;
                end
            end

            case (r_state)
                S_IDLE: begin
                    if (i_ctl.start) begin
                        r_rp    <= w_newest;
                        r_idx   <= '0;
                        r_n     <= w_n;
                        r_best  <= '0;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    r_rd_vld <= 1'b1;
                    r_rd_ok  <= (r_idx < r_fill);
                    r_rp     <= w_prev;
                    r_idx    <= r_idx + 1'b1;
                    r_best   <= w_best;
                    if (r_idx == r_n - 1'b1) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_best  <= w_best;
                    r_state <= S_FINAL;
                end
                S_FINAL: begin
                    r_shown <= (r_best <= SPEED_W'(i_min_speed)) ? '0 : r_best;
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_push_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_ctl.push && i_ctl.start))
        else $error("history push and search start together");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(DEPTH))
        else $error("history fill count beyond depth");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("search done held longer than one cycle");

endmodule

### src/gyro_stride_distance_speed.sv
// ----------------------------------------------------------------------------
// gyro_stride_distance_speed
// Stride distance and walking speed from a stream of gyro Z-rate samples
// ----------------------------------------------------------------------------
// One signed Z-rate sample is taken per transfer on the slave stream, with a
// restart flag in tuser that clears distance, peak, counters and the speed
// history before the sample is used. Each sample yields one result transfer
// holding the stride added, the saturating total distance (Q16 m), the latest
// interval speed and the shown speed (window maximum after the minimum cut,
// Q16 m/s). Samples are handled one at a time. All products go through one
// shared multiplier that takes a 4-bit digit per cycle; a sample below the
// trigger needs one product (the peak compare), one that counts a stride
// needs eight (angle, sine series, reciprocal divides, leg scaling). The
// window search then reads the history one entry per cycle, over
// window_entries clamped to 1 and SPEED_DEPTH. A new sample is taken while
// the previous result still waits in the output register. The history is a
// ring buffer with a fill count, so it needs no clearing pass after reset or
// restart. The user must write configuration through the APB port only
// while no sample is in flight; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module gyro_stride_distance_speed
    import gsds_pkg::*;
#(
    parameter int SPEED_DEPTH = 40
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // slave stream
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [15:0]        s_axis_tdata,   // [15:0] gyro_z
    input  logic [0:0]         s_axis_tuser,   // [0] restart
    // master stream
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [95:0]        m_axis_tdata,   // [15:0] step_distance,
                                               // [47:16] total_distance,
                                               // [71:48] instant_speed,
                                               // [95:72] shown_speed
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_UPD,
        S_PUSH,
        S_SRCH,
        S_OUT
    } t_state;

    // multiplier jobs in issue order
    typedef enum logic [2:0] {
        OP_TRIG,
        OP_X,
        OP_X2,
        OP_X3,
        OP_X5,
        OP_Q3,
        OP_Q5,
        OP_STEP
    } t_op;

    t_cfg               w_cfg;

    t_state             r_state;
    t_op                r_op;

    // block state
    logic [PEAK_W-1:0]  r_peak;
    logic [SUM_W-1:0]   r_sum;
    logic [SUM_W-1:0]   r_last;
    logic [CNT_W-1:0]   r_icount;
    logic [SPEED_W-1:0] r_speed;

    // per-sample working registers
    logic [ABS_W-1:0]   r_a;
    logic [X_W-1:0]     r_x;
    logic [X2_W-1:0]    r_x2;
    logic [X3_W-1:0]    r_x3;
    logic [X5_W-1:0]    r_x5;
    logic [X_W-1:0]     r_s;
    logic [STEP_W-1:0]  r_step;

    // multiplier and history control
    logic               r_mul_start;
    logic [MUL_W-1:0]   r_mul_a;
    logic [MUL_W-1:0]   r_mul_b;
    t_hist_ctl          r_ctl;

    // output register
    logic               r_m_valid;
    logic [95:0]        r_m_data;

    logic               w_accept;
    logic [ABS_W-1:0]   w_a;
    logic               w_restart;
    logic [PEAK_W-1:0]  w_peak_base;
    logic [PEAK_W-1:0]  w_peak_a;
    logic [PEAK_W-1:0]  w_peak_new;
    logic               w_mul_done;
    logic [2*MUL_W-1:0] w_prod;
    logic [X_W-1:0]     w_s_fin;
    logic [SUM_W:0]     w_sum_add;
    logic [SUM_W-1:0]   w_sum_new;
    logic [SUM_W-1:0]   w_diff;
    logic [SPEED_W-1:0] w_speed;
    logic               w_hist_done;
    logic [SPEED_W-1:0] w_shown;

    gsds_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    gsds_ser_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mul_start),
        .i_a     (r_mul_a),
        .i_b     (r_mul_b),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    gsds_spd_hist #(
        .DEPTH (SPEED_DEPTH)
    ) u_hist (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (r_ctl),
        .i_push_data (r_speed),
        .i_window    (w_cfg.window_entries),
        .i_min_speed (w_cfg.min_speed),
        .o_done      (w_hist_done),
        .o_shown     (w_shown)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    // magnitude of the sample, full scale negative gives 32768
    assign w_a       = s_axis_tdata[GYRO_W-1] ? (~s_axis_tdata + 1'b1) : s_axis_tdata;
    assign w_restart = s_axis_tuser[0];

    // peak tracking, after an optional restart, never below the floor
    assign w_peak_base = w_restart ? '0 : r_peak;
    assign w_peak_a    = (w_a > w_peak_base) ? w_a : w_peak_base;
    assign w_peak_new  = (PEAK_W'(w_cfg.peak_floor) > w_peak_a) ?
                         PEAK_W'(w_cfg.peak_floor) : w_peak_a;

    // sine series total once the fifth-order term is in
    assign w_s_fin = r_s + X_W'(w_prod[SH_Q5 +: Q5_W]);

    // saturating distance total
    assign w_sum_add = {1'b0, r_sum} + (SUM_W + 1)'(r_step);
    assign w_sum_new = w_sum_add[SUM_W] ? '1 : w_sum_add[SUM_W-1:0];

    // interval speed, twice the distance gained, saturating
    assign w_diff  = w_sum_new - r_last;
    assign w_speed = (|w_diff[SUM_W-1:SPEED_W-1]) ? '1 : {w_diff[SPEED_W-2:0], 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_TRIG;
            r_peak      <= '0;
            r_sum       <= '0;
            r_last      <= '0;
            r_icount    <= '0;
            r_speed     <= '0;
            r_a         <= '0;
            r_x         <= '0;
            r_x2        <= '0;
            r_x3        <= '0;
            r_x5        <= '0;
            r_s         <= '0;
            r_step      <= '0;
            r_mul_start <= 1'b0;
            r_mul_a     <= '0;
            r_mul_b     <= '0;
            r_ctl       <= '0;
            r_m_valid   <= 1'b0;
            r_m_data    <= '0;
        end else begin
            r_mul_start <= 1'b0;
            r_ctl       <= '0;

            // result taken downstream
            if (r_m_valid && m_axis_tready) begin
                r_m_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_a    <= w_a;
                        r_peak <= w_peak_new;
                        if (w_restart) begin
                            r_sum     <= '0;
                            r_last    <= '0;
                            r_icount  <= '0;
                            r_speed   <= '0;
                            r_ctl.clear <= 1'b1;
                        end
                        // trigger check: peak times fraction
                        r_mul_a     <= MUL_W'(w_peak_new);
                        r_mul_b     <= MUL_W'(w_cfg.trigger_fraction);
                        r_mul_start <= 1'b1;
                        r_op        <= OP_TRIG;
                        r_state     <= S_MUL;
                    end
                end

                S_MUL: begin
                    if (w_mul_done) begin
                        case (r_op)
                            OP_TRIG: begin
                                if ({r_a, 16'b0} > w_prod[MUL_W-1:0]) begin
                                    r_mul_a     <= HALF_ANGLE_Q40;
                                    r_mul_b     <= MUL_W'(r_a);
                                    r_mul_start <= 1'b1;
                                    r_op        <= OP_X;
                                end else begin
                                    r_step  <= '0;
                                    r_state <= S_UPD;
                                end
                            end
                            OP_X: begin
                                // half angle, Q32
                                r_x         <= w_prod[SH_X +: X_W];
                                r_mul_a     <= MUL_W'(w_prod[SH_X +: X_W]);
                                r_mul_b     <= MUL_W'(w_prod[SH_X +: X_W]);
                                r_mul_start <= 1'b1;
                                r_op        <= OP_X2;
                            end
                            OP_X2: begin
                                r_x2        <= w_prod[SH_SQ +: X2_W];
                                r_mul_a     <= MUL_W'(w_prod[SH_SQ +: X2_W]);
                                r_mul_b     <= MUL_W'(r_x);
                                r_mul_start <= 1'b1;
                                r_op        <= OP_X3;
                            end
                            OP_X3: begin
                                r_x3        <= w_prod[SH_SQ +: X3_W];
                                r_mul_a     <= MUL_W'(w_prod[SH_SQ +: X3_W]);
                                r_mul_b     <= MUL_W'(r_x2);
                                r_mul_start <= 1'b1;
                                r_op        <= OP_X5;
                            end
                            OP_X5: begin
                                r_x5        <= w_prod[SH_SQ +: X5_W];
                                r_mul_a     <= RECIP6;
                                r_mul_b     <= MUL_W'(r_x3);
                                r_mul_start <= 1'b1;
                                r_op        <= OP_Q3;
                            end
                            OP_Q3: begin
                                // x minus x3 / 6
                                r_s         <= r_x - X_W'(w_prod[SH_Q3 +: Q3_W]);
                                r_mul_a     <= RECIP120;
                                r_mul_b     <= MUL_W'(r_x5);
                                r_mul_start <= 1'b1;
                                r_op        <= OP_Q5;
                            end
                            OP_Q5: begin
                                // plus x5 / 120, then scale by the leg
                                r_s         <= w_s_fin;
                                r_mul_a     <= MUL_W'(w_cfg.leg_length);
                                r_mul_b     <= MUL_W'(w_s_fin);
                                r_mul_start <= 1'b1;
                                r_op        <= OP_STEP;
                            end
                            OP_STEP: begin
                                r_step  <= w_prod[SH_STEP +: STEP_W];
                                r_state <= S_UPD;
                            end
                            default: r_state <= S_UPD;
                        endcase
                    end
                end

                S_UPD: begin
                    r_sum <= w_sum_new;
                    if (r_icount >= w_cfg.interval_samples) begin
                        r_speed     <= w_speed;
                        r_last      <= w_sum_new;
                        r_icount    <= '0;
                        r_ctl.push  <= 1'b1;
                    end else begin
                        r_icount <= r_icount + 1'b1;
                    end
                    r_state <= S_PUSH;
                end

                S_PUSH: begin
                    // history write lands this cycle, search starts next
                    r_ctl.start <= 1'b1;
                    r_state     <= S_SRCH;
                end

                S_SRCH: begin
                    if (w_hist_done) begin
                        r_state <= S_OUT;
                    end
                end

                S_OUT: begin
                    if (!r_m_valid || m_axis_tready) begin
                        r_m_data  <= {w_shown, r_speed, r_sum, r_step};
                        r_m_valid <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("sample taken while another is in flight");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state) == S_OUT)
        else $error("result loaded outside the output state");

    a_sum_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) |=> r_sum >= $past(r_sum))
        else $error("distance total decreased on update");

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for gyro_stride_distance_speed
// ----------------------------------------------------------------------------
// Gyro samples go in on the slave stream and results come back on the master
// stream. A scoreboard class keeps its own copy of the registers and the block
// state and works out each result as a sample is accepted. Every result is
// then compared field by field with the oldest prediction. The run starts
// with a short directed sequence and continues with random samples under six
// register settings, extremes among them. Stall patterns change along the
// way, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_top;
    import gsds_pkg::*;

    localparam int          HIST_DEPTH  = 40;
    localparam int unsigned CYCLE_LIMIT = 2_000_000;
    localparam int          PHASE_ITEMS = 215;
    localparam int          HOLD_CYCLES = 400;
    localparam int          DRAIN_WAIT  = 150;      // worst sample, window of 40
    localparam logic [63:0] HALF_ANGLE  = 64'd4197834;

    // register indexes, byte address is index * 4
    typedef enum logic [2:0] {
        REG_LEG_LENGTH,
        REG_PEAK_FLOOR,
        REG_TRIGGER_FRAC,
        REG_MIN_SPEED,
        REG_WINDOW,
        REG_INTERVAL,
        REG_UNMAPPED
    } t_cfg_reg;

    // same layout as m_axis_tdata, step_distance in the low bits
    typedef struct packed {
        logic [SPEED_W-1:0] shown;
        logic [SPEED_W-1:0] instant;
        logic [SUM_W-1:0]   total;
        logic [STEP_W-1:0]  step;
    } t_odo_reading;

    // ------------------------------------------------------------------------
    // scoreboard: mirrors registers and state, predicts one reading per sample
    // ------------------------------------------------------------------------
    class odometer_checker;
        logic [LEG_W-1:0]   leg_length;
        logic [FLOOR_W-1:0] peak_floor;
        logic [FRAC_W-1:0]  trigger_fraction;
        logic [MINSP_W-1:0] min_speed;
        logic [WIN_W-1:0]   window_entries;
        logic [IVAL_W-1:0]  interval_samples;

        logic [PEAK_W-1:0]  peak_level;
        logic [SUM_W-1:0]   distance_sum;
        logic [SUM_W-1:0]   distance_mark;
        logic [CNT_W-1:0]   interval_count;
        logic [SPEED_W-1:0] latest_speed;
        logic [SPEED_W-1:0] speed_log [HIST_DEPTH];

        t_odo_reading readings_due [$];
        int failures;
        int samples;
        int strides;
        int restarts;
        int shown_hits;

        function new();
            leg_length       = 17'd61276;
            peak_floor       = 15'd4000;
            trigger_fraction = 16'd3277;
            min_speed        = 16'd3277;
            window_entries   = 6'd4;
            interval_samples = 8'd10;
            failures   = 0;
            samples    = 0;
            strides    = 0;
            restarts   = 0;
            shown_hits = 0;
            clear_state();
        endfunction

        function void clear_state();
            peak_level     = '0;
            distance_sum   = '0;
            distance_mark  = '0;
            interval_count = '0;
            latest_speed   = '0;
            foreach (speed_log[i]) speed_log[i] = '0;
        endfunction

        function void set_register(t_cfg_reg idx, logic [31:0] value);
            case (idx)
                REG_LEG_LENGTH:   leg_length       = value[LEG_W-1:0];
                REG_PEAK_FLOOR:   peak_floor       = value[FLOOR_W-1:0];
                REG_TRIGGER_FRAC: trigger_fraction = value[FRAC_W-1:0];
                REG_MIN_SPEED:    min_speed        = value[MINSP_W-1:0];
                REG_WINDOW:       window_entries   = value[WIN_W-1:0];
                REG_INTERVAL:     interval_samples = value[IVAL_W-1:0];
                default: ;
            endcase
        endfunction

        // chord 2*L*sin(theta/2) with a three-term sine, Q16 meters
        function logic [STEP_W-1:0] chord_length(logic [ABS_W-1:0] mag);
            logic [63:0] x, x2, x3, x5, s, scaled;
            x      = (64'(mag) * HALF_ANGLE) >> 8;
            x2     = (x * x) >> 32;
            x3     = (x2 * x) >> 32;
            x5     = (x3 * x2) >> 32;
            s      = x - x3 / 64'd6 + x5 / 64'd120;
            scaled = (64'(leg_length) * s) >> 31;
            return scaled[STEP_W-1:0];
        endfunction

        function void note_sample(logic [GYRO_W-1:0] z, logic restart);
            logic [ABS_W-1:0]   mag;
            logic [63:0]        lhs, rhs;
            logic [SUM_W:0]     sum;
            logic [SUM_W-1:0]   gain;
            logic [SUM_W:0]     speed;
            logic [SPEED_W-1:0] best;
            int                 n;
            t_odo_reading       r;

            mag = z[GYRO_W-1] ? (~z + 16'd1) : z;
            if (restart) clear_state();

            if (mag > peak_level) peak_level = mag;
            if (PEAK_W'(peak_floor) > peak_level) peak_level = PEAK_W'(peak_floor);

            r.step = '0;
            lhs = 64'(mag) << 16;
            rhs = 64'(peak_level) * 64'(trigger_fraction);
            if (lhs > rhs) begin
                r.step = chord_length(mag);
                sum = (SUM_W+1)'(distance_sum) + (SUM_W+1)'(r.step);
                distance_sum = sum[SUM_W] ? '1 : sum[SUM_W-1:0];
            end

            if (interval_count >= interval_samples) begin
                gain  = distance_sum - distance_mark;
                speed = {gain, 1'b0};
                latest_speed = (speed > 33'hFF_FFFF) ? '1 : speed[SPEED_W-1:0];
                distance_mark  = distance_sum;
                interval_count = '0;
                for (int i = 0; i < HIST_DEPTH - 1; i++) speed_log[i] = speed_log[i+1];
                speed_log[HIST_DEPTH-1] = latest_speed;
            end else begin
                interval_count = interval_count + 8'd1;
            end

            // newest entries sit at the top of the table
            n = int'(window_entries);
            if (n == 0) n = 1;
            if (n > HIST_DEPTH) n = HIST_DEPTH;
            best = '0;
            for (int i = 0; i < n; i++)
                if (speed_log[HIST_DEPTH-1-i] > best) best = speed_log[HIST_DEPTH-1-i];

            r.total   = distance_sum;
            r.instant = latest_speed;
            r.shown   = (best <= SPEED_W'(min_speed)) ? '0 : best;
            readings_due.push_back(r);

            samples++;
            if (restart) restarts++;
            if (r.step != 0) strides++;
            if (r.shown != 0) shown_hits++;
        endfunction

        function void check_result(logic [95:0] bus);
            t_odo_reading got, want;
            got = bus;
            if (readings_due.size() == 0) begin
                $error("result with no sample outstanding: %h", bus);
                failures++;
                return;
            end
            want = readings_due.pop_front();
            if (got.step !== want.step) begin
                $error("step_distance: expected %0d, got %0d", want.step, got.step);
                failures++;
            end
            if (got.total !== want.total) begin
                $error("total_distance: expected %0d, got %0d", want.total, got.total);
                failures++;
            end
            if (got.instant !== want.instant) begin
                $error("instant_speed: expected %0d, got %0d", want.instant, got.instant);
                failures++;
            end
            if (got.shown !== want.shown) begin
                $error("shown_speed: expected %0d, got %0d", want.shown, got.shown);
                failures++;
            end
        endfunction

        function int pending();
            return readings_due.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // signals and block under test
    // ------------------------------------------------------------------------
    logic               i_clk;
    logic               i_rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [15:0]        s_axis_tdata;   // [15:0] gyro_z
    logic [0:0]         s_axis_tuser;   // [0] restart
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [95:0]        m_axis_tdata;   // [15:0] step_distance, [47:16] total_distance,
                                        // [71:48] instant_speed, [95:72] shown_speed
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    odometer_checker sb;
    int              snd_idle_pct;
    int              rcv_idle_pct;
    int              hold_left;
    int unsigned     cycle_count;

    gyro_stride_distance_speed #(
        .SPEED_DEPTH (HIST_DEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // 10 ns clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // watchdog, far above the slowest legal run
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("gyro_stride_distance_speed verification failed");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold-off counted down here
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left = hold_left - 1;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
            end
        end
    end

    // result transfers are checked at the edge they complete
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end

    // ------------------------------------------------------------------------
    // drivers, all entered and left at a falling edge
    // ------------------------------------------------------------------------
    task automatic apb_write(input t_cfg_reg idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.set_register(idx, value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // bus idle between writes
        @(negedge i_clk);
    endtask

    task automatic load_config(input logic [31:0] leg, input logic [31:0] floor_v,
                               input logic [31:0] frac, input logic [31:0] minsp,
                               input logic [31:0] win, input logic [31:0] ival);
        apb_write(REG_LEG_LENGTH, leg);
        apb_write(REG_PEAK_FLOOR, floor_v);
        apb_write(REG_TRIGGER_FRAC, frac);
        apb_write(REG_MIN_SPEED, minsp);
        apb_write(REG_WINDOW, win);
        apb_write(REG_INTERVAL, ival);
    endtask

    // random settings, junk above each field to exercise masking
    task automatic random_config();
        load_config(32'($urandom_range(20000, 131071)) | ($urandom << LEG_W),
                    32'($urandom_range(0, 8000))       | ($urandom << FLOOR_W),
                    32'($urandom_range(0, 20000))      | ($urandom << FRAC_W),
                    32'($urandom_range(0, 30000))      | ($urandom << MINSP_W),
                    32'($urandom_range(0, 63))         | ($urandom << WIN_W),
                    32'($urandom_range(0, 30))         | ($urandom << IVAL_W));
    endtask

    task automatic send_sample(input logic [15:0] z, input logic restart);
        while ($urandom_range(99) < snd_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= z;
        s_axis_tuser  <= restart;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_sample(z, restart);
        @(negedge i_clk);
    endtask

    // mix of full-range noise, stride-sized swings, small drift and extremes
    function automatic logic [15:0] random_rate();
        logic [15:0] z;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: z = 16'($urandom);
            4, 5, 6:    z = 16'($urandom_range(8000, 32767));
            7:          z = 16'($urandom_range(0, 500));
            8: begin
                case ($urandom_range(0, 3))
                    0:       z = 16'h8000;
                    1:       z = 16'h7FFF;
                    2:       z = 16'h0000;
                    default: z = 16'hFFFF;
                endcase
            end
            default:    z = 16'($urandom_range(0, 4000));
        endcase
        if (z != 16'h8000 && $urandom_range(0, 1) == 1) z = ~z + 16'd1;
        return z;
    endfunction

    task automatic run_random(input int count);
        for (int i = 0; i < count; i++)
            send_sample(random_rate(), $urandom_range(0, 63) == 0);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    // trigger edge at reset values: 200 stays under floor * fraction, 201 passes;
    // the restart is followed by exactly one interval of strides
    logic [15:0] opening_z [22] = '{
        16'd200,   16'd201,   16'hFF37,  16'h0000,  16'h0001,  16'hFFFF,
        16'd4000,  16'h5555,  16'hAAAA,  16'h7FFF,  16'h8000,  16'h7FFF,
        16'd12000, 16'hD120,  16'd9000,  16'hDCD8,  16'd6000,  16'hE890,
        16'd3000,  16'd100,   16'hFF9C,  16'h0800
    };

    initial begin
        sb            = new();
        snd_idle_pct  = 28;
        rcv_idle_pct  = 66;
        hold_left     = 0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed samples at reset register values
        foreach (opening_z[i]) send_sample(opening_z[i], i == 11);
        wait_drained();

        // max leg, no floor, triggers on any nonzero sample, speed on every sample, window of zero;
        // a write to an unmapped address must change nothing
        load_config(32'd131071, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
        apb_write(REG_UNMAPPED, 32'hFFFF_FFFF);
        run_random(PHASE_ITEMS);
        wait_drained();

        // opposite extremes: zero leg, top floor and fraction, window past the table
        load_config(32'd0, 32'd32767, 32'd65535, 32'd65535, 32'd63, 32'd255);
        run_random(PHASE_ITEMS);
        wait_drained();

        snd_idle_pct = 66;
        rcv_idle_pct = 28;
        random_config();
        run_random(PHASE_ITEMS);
        wait_drained();

        // long interval, so the next setting lowers it under a running count
        load_config(32'd61276, 32'd4000, 32'd3277, 32'd3277, 32'd40, 32'd40);
        run_random(PHASE_ITEMS);
        wait_drained();

        // back to back with a long receiver hold-off so the input backs up
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        apb_write(REG_INTERVAL, 32'd2);
        hold_left = HOLD_CYCLES;
        run_random(PHASE_ITEMS);
        wait_drained();

        random_config();
        run_random(PHASE_ITEMS);
        wait_drained();

        // catch any stray result after the last expected one
        repeat (DRAIN_WAIT) @(negedge i_clk);

        $display("%0d samples over six register settings: %0d strides, %0d restarts",
                 sb.samples, sb.strides, sb.restarts);
        $display("%0d readings above the speed cut, one receiver hold-off of %0d cycles",
                 sb.shown_hits, HOLD_CYCLES);
        if (sb.failures == 0) begin
            $display("gyro_stride_distance_speed verification clean");
        end else begin
            $display("gyro_stride_distance_speed verification failed");
        end
        $finish;
    end

endmodule
